// File: sv/go_back_n_sender_assert.svh
// Assertion macros shared by the go-back-n sender.
`ifndef GO_BACK_N_SENDER_ASSERT_SVH
`define GO_BACK_N_SENDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBN_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GBN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/gbn_pkg.sv
// Package with the types, codes and constants of the go-back-n sender.
`timescale 1ns / 1ps

package gbn_pkg;

    localparam int unsigned WINDOW_DEF = 8;
    localparam logic [31:0] NO_ACK_DEF = 32'hFFFF_FFFF;
    localparam int unsigned MAX_SENDS  = 8;
    localparam int unsigned CNT_W      = $clog2(MAX_SENDS);
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_PUMP  = 2'd1,
        CMD_DGRAM = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DG_DATA  = 2'd0,
        DG_ACK   = 2'd1,
        DG_START = 2'd2,
        DG_END   = 2'd3
    } dgram_t;

    typedef enum logic [1:0] {
        SK_NONE  = 2'd0,
        SK_START = 2'd1,
        SK_DATA  = 2'd2,
        SK_END   = 2'd3
    } send_kind_t;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_DATA   = 3'd1,
        PH_END    = 3'd2,
        PH_DONE   = 3'd3,
        PH_FAILED = 3'd4
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PEER_ADDR   = 3'd0,
        CFG_PEER_PORT   = 3'd1,
        CFG_XFER_ID     = 3'd2,
        CFG_LOCAL_ID    = 3'd3,
        CFG_REMOTE_ID   = 3'd4,
        CFG_FRAG_TOTAL  = 3'd5,
        CFG_TIMEOUT     = 3'd6,
        CFG_RETRY_LIMIT = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic load_item;
        logic do_tick;
        logic do_ack;
        logic do_timeout;
        logic data_close;
        logic clr_cnt;
        logic emit_none;
        logic emit_ctrl;
        logic emit_data;
    } gbn_cmd_t;

    typedef struct packed {
        cmd_t   item_cmd;
        phase_t phase;
        logic   awaiting;
        logic   first_ok;
        logic   more_ok;
        logic   slot_free;
    } gbn_stat_t;

endpackage

// File: sv/gbn_ctrl.sv
// Controller state machine that sequences each input word of the sender.
`timescale 1ns / 1ps

module gbn_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gbn_pkg::gbn_stat_t  stat,
    output gbn_pkg::gbn_cmd_t   cmd
);
    import gbn_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_PLAN   = 7'b0000100,
        ST_CTRL   = 7'b0001000,
        ST_DATA   = 7'b0010000,
        ST_FIN    = 7'b0100000,
        ST_NONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.item_cmd)
                    CMD_TICK: begin
                        cmd.do_tick = 1'b1;
                        state_next  = ST_NONE;
                    end
                    CMD_DGRAM: begin
                        cmd.do_ack = 1'b1;
                        state_next = ST_NONE;
                    end
                    CMD_PUMP: begin
                        if (stat.phase == PH_DONE || stat.phase == PH_FAILED) begin
                            state_next = ST_NONE;
                        end else begin
                            cmd.do_timeout = 1'b1;
                            state_next     = ST_PLAN;
                        end
                    end
                    default: begin
                        state_next = ST_NONE;
                    end
                endcase
            end
            ST_PLAN: begin
                if (stat.awaiting) begin
                    state_next = ST_NONE;
                end else begin
                    case (stat.phase)
                        PH_START, PH_END: begin
                            state_next = ST_CTRL;
                        end
                        PH_DATA: begin
                            if (stat.first_ok) begin
                                cmd.clr_cnt = 1'b1;
                                state_next  = ST_DATA;
                            end else begin
                                cmd.data_close = 1'b1;
                                state_next     = ST_NONE;
                            end
                        end
                        default: begin
                            state_next = ST_NONE;
                        end
                    endcase
                end
            end
            ST_CTRL: begin
                if (stat.slot_free) begin
                    cmd.emit_ctrl = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DATA: begin
                if (stat.slot_free) begin
                    cmd.emit_data = 1'b1;
                    if (!stat.more_ok) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                cmd.data_close = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_NONE: begin
                if (stat.slot_free) begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/gbn_dp.sv
// Datapath with the configuration, transfer state and output register of the sender.
`timescale 1ns / 1ps

module gbn_dp #(
    parameter int unsigned WINDOW = gbn_pkg::WINDOW_DEF,
    parameter logic [31:0] NO_ACK = gbn_pkg::NO_ACK_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [1:0]                        s_cmd,
    input  logic [1:0]                        s_dgram_type,
    input  logic [31:0]                       s_ack_num,
    input  logic [31:0]                       s_msg_xfer_id,
    input  logic [15:0]                       s_msg_src_id,
    input  logic [15:0]                       s_msg_dst_id,
    input  logic [31:0]                       s_from_addr,
    input  logic [15:0]                       s_from_port,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_send_kind,
    output logic [31:0]                       m_send_seq,
    output logic [2:0]                        m_phase_now,
    output logic [7:0]                        m_retry_count,
    output logic                              m_last,
    input  gbn_pkg::gbn_cmd_t                 cmd,
    output gbn_pkg::gbn_stat_t                stat
);
    import gbn_pkg::*;

    logic [31:0] peer_addr_reg;
    logic [15:0] peer_port_reg;
    logic [31:0] xfer_id_reg;
    logic [15:0] local_id_reg;
    logic [15:0] remote_id_reg;
    logic [31:0] frag_total_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  retry_limit_reg;

    cmd_t        item_cmd_reg;
    logic [1:0]  item_type_reg;
    logic [31:0] item_ack_reg;
    logic [31:0] item_xfer_reg;
    logic [15:0] item_src_reg;
    logic [15:0] item_dst_reg;
    logic [31:0] item_addr_reg;
    logic [15:0] item_port_reg;

    phase_t           phase_reg, phase_next;
    logic [31:0]      base_reg, base_next;
    logic [31:0]      next_seq_reg, next_seq_next;
    logic [7:0]       retries_reg, retries_next;
    logic             awaiting_reg, awaiting_next;
    logic [15:0]      elapsed_reg, elapsed_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    logic [1:0]  m_kind_reg;
    logic [31:0] m_seq_reg;
    logic [2:0]  m_phase_reg;
    logic [7:0]  m_retry_reg;
    logic        m_last_reg;

    logic [32:0] lim;
    logic [32:0] seq_p1;
    logic [32:0] total_ext;
    logic [32:0] seq_ext;
    logic        first_ok;
    logic        more_ok;
    logic        ack_match;
    logic        ack_in_win;
    logic [31:0] ack_p1;
    logic        timeout_hit;
    logic [8:0]  retries_p1;
    logic        slot_free;
    logic        emit_any;

    assign lim       = {1'b0, base_reg} + 33'(WINDOW);
    assign total_ext = {1'b0, frag_total_reg};
    assign seq_ext   = {1'b0, next_seq_reg};
    assign seq_p1    = seq_ext + 33'd1;
    assign first_ok  = (seq_ext < total_ext) && (seq_ext < lim);
    assign more_ok   = (seq_p1 < total_ext) && (seq_p1 < lim)
                       && (cnt_reg != CNT_W'(MAX_SENDS - 1));

    assign ack_match = (item_addr_reg == peer_addr_reg) && (item_port_reg == peer_port_reg)
                       && (dgram_t'(item_type_reg) == DG_ACK)
                       && (item_xfer_reg == xfer_id_reg)
                       && (item_src_reg == remote_id_reg) && (item_dst_reg == local_id_reg);
    assign ack_in_win = (item_ack_reg >= base_reg) && (item_ack_reg < frag_total_reg);
    assign ack_p1     = item_ack_reg + 32'd1;

    assign timeout_hit = awaiting_reg && (elapsed_reg >= timeout_reg);
    assign retries_p1  = {1'b0, retries_reg} + 9'd1;

    assign slot_free = !m_valid_reg || m_ready;
    assign emit_any  = cmd.emit_none || cmd.emit_ctrl || cmd.emit_data;

    always_comb begin
        stat.item_cmd  = item_cmd_reg;
        stat.phase     = phase_reg;
        stat.awaiting  = awaiting_reg;
        stat.first_ok  = first_ok;
        stat.more_ok   = more_ok;
        stat.slot_free = slot_free;
    end

    always_comb begin
        phase_next    = phase_reg;
        base_next     = base_reg;
        next_seq_next = next_seq_reg;
        retries_next  = retries_reg;
        awaiting_next = awaiting_reg;
        elapsed_next  = elapsed_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;

        if (cmd.do_tick && elapsed_reg != 16'hFFFF) begin
            elapsed_next = elapsed_reg + 16'd1;
        end

        if (cmd.do_ack && ack_match) begin
            case (phase_reg)
                PH_START: begin
                    if (item_ack_reg == NO_ACK) begin
                        phase_next    = PH_DATA;
                        awaiting_next = 1'b0;
                        retries_next  = '0;
                    end
                end
                PH_DATA: begin
                    if (item_ack_reg == NO_ACK) begin
                        base_next     = '0;
                        next_seq_next = '0;
                        awaiting_next = 1'b0;
                    end else if (ack_in_win) begin
                        base_next    = ack_p1;
                        retries_next = '0;
                        if (ack_p1 == frag_total_reg) begin
                            phase_next    = PH_END;
                            awaiting_next = 1'b0;
                        end else if (ack_p1 == next_seq_reg) begin
                            awaiting_next = 1'b0;
                        end else begin
                            elapsed_next = '0;
                        end
                    end
                end
                PH_END: begin
                    if (item_ack_reg == frag_total_reg) begin
                        phase_next    = PH_DONE;
                        awaiting_next = 1'b0;
                        retries_next  = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.do_timeout && timeout_hit) begin
            retries_next = retries_p1[8] ? 8'hFF : retries_p1[7:0];
            if (retries_p1 > {1'b0, retry_limit_reg}) begin
                phase_next = PH_FAILED;
            end else begin
                if (phase_reg == PH_DATA) begin
                    next_seq_next = base_reg;
                end
                awaiting_next = 1'b0;
            end
        end

        if (cmd.data_close) begin
            awaiting_next = (base_reg < next_seq_reg);
            elapsed_next  = '0;
        end

        if (cmd.emit_ctrl) begin
            awaiting_next = 1'b1;
            elapsed_next  = '0;
        end

        if (cmd.clr_cnt) begin
            cnt_next = '0;
        end

        if (cmd.emit_data) begin
            next_seq_next = next_seq_reg + 32'd1;
            cnt_next      = cnt_reg + CNT_W'(1);
        end

        if (emit_any) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peer_addr_reg   <= '0;
            peer_port_reg   <= '0;
            xfer_id_reg     <= '0;
            local_id_reg    <= '0;
            remote_id_reg   <= '0;
            frag_total_reg  <= '0;
            timeout_reg     <= 16'd500;
            retry_limit_reg <= 8'd5;
            phase_reg       <= PH_START;
            base_reg        <= '0;
            next_seq_reg    <= '0;
            retries_reg     <= '0;
            awaiting_reg    <= 1'b0;
            elapsed_reg     <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_PEER_ADDR:   peer_addr_reg   <= cfg_wdata;
                    CFG_PEER_PORT:   peer_port_reg   <= cfg_wdata[15:0];
                    CFG_XFER_ID:     xfer_id_reg     <= cfg_wdata;
                    CFG_LOCAL_ID:    local_id_reg    <= cfg_wdata[15:0];
                    CFG_REMOTE_ID:   remote_id_reg   <= cfg_wdata[15:0];
                    CFG_FRAG_TOTAL:  frag_total_reg  <= cfg_wdata;
                    CFG_TIMEOUT:     timeout_reg     <= cfg_wdata[15:0];
                    CFG_RETRY_LIMIT: retry_limit_reg <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
            phase_reg    <= phase_next;
            base_reg     <= base_next;
            next_seq_reg <= next_seq_next;
            retries_reg  <= retries_next;
            awaiting_reg <= awaiting_next;
            elapsed_reg  <= elapsed_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_cmd_reg  <= cmd_t'(s_cmd);
            item_type_reg <= s_dgram_type;
            item_ack_reg  <= s_ack_num;
            item_xfer_reg <= s_msg_xfer_id;
            item_src_reg  <= s_msg_src_id;
            item_dst_reg  <= s_msg_dst_id;
            item_addr_reg <= s_from_addr;
            item_port_reg <= s_from_port;
        end
        if (emit_any) begin
            m_phase_reg <= phase_reg;
            m_retry_reg <= retries_reg;
            if (cmd.emit_data) begin
                m_kind_reg <= SK_DATA;
                m_seq_reg  <= next_seq_reg;
                m_last_reg <= !more_ok;
            end else if (cmd.emit_ctrl) begin
                m_kind_reg <= (phase_reg == PH_START) ? SK_START : SK_END;
                m_seq_reg  <= (phase_reg == PH_START) ? 32'd0 : frag_total_reg;
                m_last_reg <= 1'b1;
            end else begin
                m_kind_reg <= SK_NONE;
                m_seq_reg  <= '0;
                m_last_reg <= 1'b1;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_send_kind   = m_kind_reg;
    assign m_send_seq    = m_seq_reg;
    assign m_phase_now   = m_phase_reg;
    assign m_retry_count = m_retry_reg;
    assign m_last        = m_last_reg;

endmodule

// File: sv/go_back_n_sender.sv
// Top level of the go-back-n sender: controller, datapath and assertions.
// A tick, datagram or non-data pump offers its single word after decode (and plan, for a live pump).
// A data-phase pump offers up to 8 DATA words after planning, one per cycle unless stalled.
// The next input word is taken only once the last word of the item is offered, and after a pump
// that sends DATA words only after the closing state; output stalls add to both.
// Synchronous active-low reset restores the start phase and the configuration reset values.
`timescale 1ns / 1ps
`include "go_back_n_sender_assert.svh"

module go_back_n_sender #(
    parameter int unsigned WINDOW = gbn_pkg::WINDOW_DEF,
    parameter logic [31:0] NO_ACK = gbn_pkg::NO_ACK_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_cmd,
    input  logic [1:0]                        s_dgram_type,
    input  logic [31:0]                       s_ack_num,
    input  logic [31:0]                       s_msg_xfer_id,
    input  logic [15:0]                       s_msg_src_id,
    input  logic [15:0]                       s_msg_dst_id,
    input  logic [31:0]                       s_from_addr,
    input  logic [15:0]                       s_from_port,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_send_kind,
    output logic [31:0]                       m_send_seq,
    output logic [2:0]                        m_phase_now,
    output logic [7:0]                        m_retry_count,
    output logic                              m_last
);
    import gbn_pkg::*;

    gbn_cmd_t  ctrl_cmd;
    gbn_stat_t dp_stat;
    logic      in_fire;
    logic      out_emit;
    logic      out_data_word;

    gbn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (ctrl_cmd)
    );

    gbn_dp #(
        .WINDOW (WINDOW),
        .NO_ACK (NO_ACK)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_cmd         (s_cmd),
        .s_dgram_type  (s_dgram_type),
        .s_ack_num     (s_ack_num),
        .s_msg_xfer_id (s_msg_xfer_id),
        .s_msg_src_id  (s_msg_src_id),
        .s_msg_dst_id  (s_msg_dst_id),
        .s_from_addr   (s_from_addr),
        .s_from_port   (s_from_port),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_send_kind   (m_send_kind),
        .m_send_seq    (m_send_seq),
        .m_phase_now   (m_phase_now),
        .m_retry_count (m_retry_count),
        .m_last        (m_last),
        .cmd           (ctrl_cmd),
        .stat          (dp_stat)
    );

    assign in_fire       = s_valid && s_ready;
    assign out_emit      = ctrl_cmd.emit_none || ctrl_cmd.emit_ctrl || ctrl_cmd.emit_data;
    assign out_data_word = m_valid && (m_send_kind == SK_DATA);

    // An accepted word is decoded before anything is offered on the output.
    `GBN_ASSERT_NOW(a_no_emit_on_accept, aclk, aresetn, in_fire, !out_emit)
    `GBN_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_fire, !s_ready)
    `GBN_ASSERT_NOW(a_data_in_data_phase, aclk, aresetn, ctrl_cmd.emit_data, dp_stat.phase == PH_DATA)
    `GBN_ASSERT_NOW(a_data_word_phase, aclk, aresetn, out_data_word, m_phase_now == PH_DATA)

endmodule
